// ===== rtl/core/shortest_path_finder_macros.svh =====
// assertion macros for the shortest path finder core
// used by the datapath; expects i_clk and i_rst_n in scope
`ifndef SHORTEST_PATH_FINDER_MACROS_SVH
`define SHORTEST_PATH_FINDER_MACROS_SVH
`ifndef ASSERT_OFF
`define SPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SPF_ASSERT(label, prop, msg)
`define SPF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/core/spf_pkg.sv =====
// types, constants and codes for the shortest path finder
// no dependencies
`default_nettype none
package spf_pkg;
    localparam int MAX_NODES     = 16;
    localparam int WEIGHT_BITS   = 16;
    localparam int NODE_BITS     = $clog2(MAX_NODES);
    localparam int CNT_BITS      = NODE_BITS + 1;
    localparam int ADDR_BITS     = 2 * NODE_BITS;
    localparam int MATRIX_DEPTH  = MAX_NODES * MAX_NODES;
    localparam int COST_BITS     = 20;
    localparam int VTX_BITS      = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNDIRECTED   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START        = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END          = 2'd3;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [VTX_BITS-1:0]    edge_from;
        logic [VTX_BITS-1:0]    edge_to;
        logic [WEIGHT_BITS-1:0] edge_weight;
    } t_in_word;

    typedef struct packed {
        logic [VTX_BITS-1:0]  path_vertex;
        logic [COST_BITS-1:0] path_cost;
        logic                 found;
        logic                 last;
    } t_out_word;

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_CLEAR, DP_EDGE_RD, DP_EDGE_WR, DP_INIT, DP_VISIT,
        DP_RELAX, DP_SEL_START, DP_SELECT, DP_WALK_START, DP_WALK, DP_EMIT,
        DP_NOPATH
    } t_dp_op;

    typedef struct packed {
        logic relax_done;
        logic sel_done;
        logic have;
        logic end_done;
        logic walk_last;
        logic emit_last;
        logic out_free;
        logic range_bad;
        logic undirected;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE_RD, S_EDGE_WR, S_INIT, S_VISIT, S_RELAX, S_SEL_START,
        S_SELECT, S_WALK_START, S_WALK, S_EMIT, S_NOPATH
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/core/spf_ctrl.sv =====
// sequencing state machine for edge loads and the path search
// depends on spf_pkg
`default_nettype none
module spf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_cmd,
    input  wire spf_pkg::t_dp_stat i_stat,
    output spf_pkg::t_dp_op        o_op,
    output logic                   o_in_ready
);
    import spf_pkg::*;

    t_state r_state, n_state;
    logic   r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_ADD: begin
                            n_state  = S_EDGE_RD;
                            n_second = 1'b0;
                        end
                        CMD_RUN: n_state = i_stat.range_bad ? S_NOPATH : S_INIT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EDGE_RD: n_state = S_EDGE_WR;
            S_EDGE_WR: begin
                if (i_stat.undirected && !r_second) begin
                    n_state  = S_EDGE_RD;
                    n_second = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INIT:      n_state = S_VISIT;
            S_VISIT:     n_state = S_RELAX;
            S_RELAX:     if (i_stat.relax_done) n_state = S_SEL_START;
            S_SEL_START: n_state = S_SELECT;
            S_SELECT: begin
                if (i_stat.sel_done) begin
                    if (i_stat.have)          n_state = S_VISIT;
                    else if (i_stat.end_done) n_state = S_WALK_START;
                    else                      n_state = S_NOPATH;
                end
            end
            S_WALK_START: n_state = S_WALK;
            S_WALK:       if (i_stat.walk_last) n_state = S_EMIT;
            S_EMIT:       if (i_stat.out_free && i_stat.emit_last) n_state = S_IDLE;
            S_NOPATH:     if (i_stat.out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op       = DP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_ADD:   o_op = DP_LOAD;
                        CMD_CLEAR: o_op = DP_CLEAR;
                        default:   o_op = DP_NOP;
                    endcase
                end
            end
            S_EDGE_RD:    o_op = DP_EDGE_RD;
            S_EDGE_WR:    o_op = DP_EDGE_WR;
            S_INIT:       o_op = DP_INIT;
            S_VISIT:      o_op = DP_VISIT;
            S_RELAX:      o_op = DP_RELAX;
            S_SEL_START:  o_op = DP_SEL_START;
            S_SELECT:     o_op = DP_SELECT;
            S_WALK_START: o_op = DP_WALK_START;
            S_WALK:       o_op = DP_WALK;
            S_EMIT:       o_op = DP_EMIT;
            S_NOPATH:     o_op = DP_NOPATH;
            default:      o_op = DP_NOP;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/spf_dpath.sv =====
// datapath: config registers, weight matrix, distance arrays, path stack, output word
// depends on spf_pkg and the assertion macros
`default_nettype none
`include "shortest_path_finder_macros.svh"
module spf_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire spf_pkg::t_dp_op                     i_op,
    input  wire spf_pkg::t_in_word                   i_in,
    input  wire logic                                i_cfg_valid,
    input  wire logic [spf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [spf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire logic                                i_out_ready,
    output spf_pkg::t_dp_stat                        o_stat,
    output logic                                     o_out_valid,
    output spf_pkg::t_out_word                       o_out
);
    import spf_pkg::*;

    // configuration
    logic [4:0]          r_vcount;
    logic                r_undir;
    logic [VTX_BITS-1:0] r_start, r_end;
    logic [CNT_BITS-1:0] w_n;

    // loaded edge
    logic [VTX_BITS-1:0]    r_a, r_b;
    logic [WEIGHT_BITS-1:0] r_w;

    // matrix
    logic [WEIGHT_BITS-1:0]  mem [MATRIX_DEPTH];
    logic [MATRIX_DEPTH-1:0] r_evalid;
    logic [WEIGHT_BITS-1:0]  r_rd_w;
    logic                    r_rd_v;
    logic [ADDR_BITS-1:0]    w_rd_addr, w_wr_addr;
    logic                    w_rd_en, w_wr_en, w_edge_ok;

    // search state
    logic [COST_BITS-1:0] r_dist [MAX_NODES];
    logic [NODE_BITS-1:0] r_pred [MAX_NODES];
    logic [MAX_NODES-1:0] r_vis, r_reach, r_haspred;
    logic [NODE_BITS-1:0] r_v, r_cand, r_ri, r_p, r_k;
    logic [COST_BITS-1:0] r_dv, r_best, r_cost;
    logic [CNT_BITS-1:0]  r_cnt, r_len;
    logic                 r_rvalid, r_have, r_end_done;
    logic [VTX_BITS-1:0]  r_stack [MAX_NODES];

    logic [NODE_BITS-1:0] w_didx, w_cidx;
    logic [COST_BITS-1:0] w_drd, w_nd;
    logic                 w_upd, w_sel_hit, w_issue, w_out_free;

    t_out_word r_out;
    logic      r_ov;

    // vertex count 0 acts as 1, above the maximum as the maximum
    always_comb begin
        if (r_vcount == 5'd0)
            w_n = CNT_BITS'(1);
        else if ({1'b0, r_vcount} > 6'(MAX_NODES))
            w_n = CNT_BITS'(MAX_NODES);
        else
            w_n = CNT_BITS'(r_vcount);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 5'd16;
            r_undir  <= 1'b0;
            r_start  <= '0;
            r_end    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vcount <= i_cfg_data[4:0];
                CFG_UNDIRECTED:   r_undir  <= i_cfg_data[0];
                CFG_START:        r_start  <= i_cfg_data[VTX_BITS-1:0];
                CFG_END:          r_end    <= i_cfg_data[VTX_BITS-1:0];
                default:          r_undir  <= r_undir;
            endcase
        end
    end

    assign w_cidx    = r_cnt[NODE_BITS-1:0];
    assign w_issue   = (i_op == DP_RELAX) && (r_cnt < w_n);
    assign w_edge_ok = ({1'b0, r_a} < CNT_BITS'(MAX_NODES)) &&
                       ({1'b0, r_b} < CNT_BITS'(MAX_NODES));
    assign w_wr_addr = {r_a[NODE_BITS-1:0], r_b[NODE_BITS-1:0]};
    assign w_rd_addr = (i_op == DP_RELAX) ? {r_v, w_cidx} : w_wr_addr;
    assign w_rd_en   = (i_op == DP_EDGE_RD) || w_issue;
    // parallel edges keep the smaller weight
    assign w_wr_en   = (i_op == DP_EDGE_WR) && w_edge_ok && (!r_rd_v || r_w < r_rd_w);

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_w <= mem[w_rd_addr];
            r_rd_v <= r_evalid[w_rd_addr];
        end
        if (w_wr_en)
            mem[w_wr_addr] <= r_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_evalid <= '0;
        else if (i_op == DP_CLEAR)
            r_evalid <= '0;
        else if (w_wr_en)
            r_evalid[w_wr_addr] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_op == DP_LOAD) begin
            r_a <= i_in.edge_from;
            r_b <= i_in.edge_to;
            r_w <= i_in.edge_weight;
        end else if (i_op == DP_EDGE_WR) begin
            // swap for the mirrored edge
            r_a <= r_b;
            r_b <= r_a;
        end
    end

    assign w_didx    = (i_op == DP_RELAX) ? r_ri : w_cidx;
    assign w_drd     = r_dist[w_didx];
    assign w_nd      = r_dv + COST_BITS'(r_rd_w);
    assign w_upd     = r_rvalid && r_rd_v && !r_vis[r_ri] &&
                       (!r_reach[r_ri] || w_nd < w_drd);
    assign w_sel_hit = (i_op == DP_SELECT) && (r_cnt < w_n) && !r_vis[w_cidx] &&
                       r_reach[w_cidx] && (!r_have || w_drd < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid   <= 1'b0;
            r_vis      <= '0;
            r_reach    <= '0;
            r_haspred  <= '0;
            r_have     <= 1'b0;
            r_end_done <= 1'b0;
        end else begin
            case (i_op)
                DP_INIT: begin
                    r_vis            <= '0;
                    r_haspred        <= '0;
                    r_reach          <= MAX_NODES'(1) << r_start[NODE_BITS-1:0];
                    r_dist[r_start[NODE_BITS-1:0]]  <= '0;
                    r_cand           <= r_start[NODE_BITS-1:0];
                    r_best           <= '0;
                    r_end_done       <= 1'b0;
                end
                DP_VISIT: begin
                    r_v           <= r_cand;
                    r_dv          <= r_best;
                    r_vis[r_cand] <= 1'b1;
                    r_cnt         <= '0;
                    r_rvalid      <= 1'b0;
                    if (r_cand == r_end[NODE_BITS-1:0]) begin
                        r_end_done <= 1'b1;
                        r_cost     <= r_best;
                    end
                end
                DP_RELAX: begin
                    r_rvalid <= w_issue;
                    if (w_issue) begin
                        r_ri  <= w_cidx;
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (w_upd) begin
                        r_dist[r_ri]    <= w_nd;
                        r_reach[r_ri]   <= 1'b1;
                        r_pred[r_ri]    <= r_v;
                        r_haspred[r_ri] <= 1'b1;
                    end
                end
                DP_SEL_START: begin
                    r_cnt  <= '0;
                    r_have <= 1'b0;
                end
                DP_SELECT: begin
                    if (r_cnt < w_n)
                        r_cnt <= r_cnt + 1'b1;
                    if (w_sel_hit) begin
                        r_have <= 1'b1;
                        r_best <= w_drd;
                        r_cand <= w_cidx;
                    end
                end
                DP_WALK_START: begin
                    r_p   <= r_end[NODE_BITS-1:0];
                    r_len <= '0;
                end
                DP_WALK: begin
                    r_stack[r_len[NODE_BITS-1:0]] <= VTX_BITS'(r_p);
                    r_len <= r_len + 1'b1;
                    r_k   <= r_len[NODE_BITS-1:0];
                    r_p   <= r_pred[r_p];
                end
                DP_EMIT: begin
                    if (w_out_free)
                        r_k <= r_k - 1'b1;
                end
                default: r_rvalid <= 1'b0;
            endcase
        end
    end

    assign w_out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_free && (i_op == DP_EMIT || i_op == DP_NOPATH)) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && i_op == DP_EMIT) begin
            r_out.path_vertex <= r_stack[r_k];
            r_out.path_cost   <= r_cost;
            r_out.found       <= 1'b1;
            r_out.last        <= (r_k == '0);
        end else if (w_out_free && i_op == DP_NOPATH) begin
            r_out.path_vertex <= '0;
            r_out.path_cost   <= '0;
            r_out.found       <= 1'b0;
            r_out.last        <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_comb begin
        o_stat.relax_done = (r_cnt == w_n) && !r_rvalid;
        o_stat.sel_done   = (r_cnt == w_n);
        o_stat.have       = r_have;
        o_stat.end_done   = r_end_done;
        o_stat.walk_last  = !r_haspred[r_p] || ((r_len + 1'b1) >= w_n);
        o_stat.emit_last  = (r_k == '0);
        o_stat.out_free   = w_out_free;
        o_stat.range_bad  = ({1'b0, r_start} >= w_n) || ({1'b0, r_end} >= w_n);
        o_stat.undirected = r_undir;
    end

    `SPF_ASSERT(a_rvalid_in_relax, r_rvalid |-> (i_op == DP_RELAX), "relax read in flight outside relax")
    `SPF_ASSERT(a_emit_when_free, (i_op == DP_EMIT) |-> w_out_free || !r_ov || !i_out_ready, "emit without room")
    `SPF_ASSERT(a_nopath_is_last, (r_ov && !r_out.found) |-> r_out.last, "no-path word not marked last")
    `SPF_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_ov, "output valid after reset")
endmodule
`default_nettype wire

// ===== rtl/core/shortest_path_finder.sv =====
// shortest path finder: array Dijkstra over a 16-vertex weight matrix
// add edge: matrix read then write, again when mirrored; clear drops all edges;
// a run relaxes and selects per visited vertex (one matrix read per relax step,
// one vertex per select step), then one path word per cycle when the sink is ready
// throughput: one item at a time; a new item is taken once the previous one is done
// reset: synchronous active low, clears all edges and loads register defaults
`default_nettype none
module shortest_path_finder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire spf_pkg::t_in_word                   i_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output spf_pkg::t_out_word                       o_out,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [spf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [spf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import spf_pkg::*;

    t_dp_op   w_op;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    spf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_in.cmd),
        .i_stat     (w_stat),
        .o_op       (w_op),
        .o_in_ready (o_in_ready)
    );

    spf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

// ===== tb/sv/shortest_path_finder_test.sv =====
// testbench for the shortest path finder: edge loads, clears and path runs
// checked word by word against a matrix dijkstra predictor; depends on spf_pkg
`timescale 1ns / 100ps
`default_nettype none
module shortest_path_finder_test;
    import spf_pkg::*;

    // command code with no function
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef struct {
        t_row_kind                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        t_in_word                 word;
        bit                       typed;
        t_out_word                typed_word;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     in_valid;
    logic                     o_in_ready;
    t_in_word                 in_word;
    logic                     o_out_valid;
    logic                     out_ready;
    t_out_word                o_out;
    logic                     cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // predictor state
    logic [WEIGHT_BITS:0] edge_w [MAX_NODES*MAX_NODES];
    logic [4:0]           n_reg;
    logic                 undir_reg;
    logic [3:0]           src_reg;
    logic [3:0]           dst_reg;

    t_out_word path_q[$];
    t_row      rows[$];
    int        mismatches;
    int        items;
    bit        calm;

    shortest_path_finder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void store_edge(int a, int b, logic [WEIGHT_BITS-1:0] w);
        int k;
        k = a * MAX_NODES + b;
        if (!edge_w[k][WEIGHT_BITS] || w < edge_w[k][WEIGHT_BITS-1:0]) begin
            edge_w[k] = {1'b1, w};
        end
    endfunction

    // dijkstra with lowest-index tie break, queues the path words
    function automatic void predict_path();
        int          n, v, len;
        bit          have;
        bit          seen [MAX_NODES];
        bit          reach [MAX_NODES];
        bit          has_pred [MAX_NODES];
        int unsigned best_dist [MAX_NODES];
        int          pred [MAX_NODES];
        int          stack [MAX_NODES];
        int unsigned nd;
        t_out_word   o;
        n = n_reg;
        if (n == 0) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        if (src_reg >= n || dst_reg >= n) begin
            path_q.insert(path_q.size(), '{path_vertex: 0, path_cost: 0, found: 0, last: 1});
            return;
        end
        for (int i = 0; i < MAX_NODES; i++) begin
            seen[i] = 0; reach[i] = 0; has_pred[i] = 0; best_dist[i] = 0; pred[i] = 0;
        end
        reach[src_reg] = 1;
        v = src_reg;
        have = 1;
        while (have) begin
            seen[v] = 1;
            for (int i = 0; i < n; i++) begin
                if (edge_w[v*MAX_NODES+i][WEIGHT_BITS] && !seen[i]) begin
                    nd = best_dist[v] + edge_w[v*MAX_NODES+i][WEIGHT_BITS-1:0];
                    if (!reach[i] || nd < best_dist[i]) begin
                        best_dist[i] = nd; reach[i] = 1; pred[i] = v; has_pred[i] = 1;
                    end
                end
            end
            have = 0;
            for (int i = 0; i < n; i++) begin
                if (!seen[i] && reach[i] && (!have || best_dist[i] < best_dist[v])) begin
                    v = i;
                    have = 1;
                end
            end
        end
        if (!reach[dst_reg]) begin
            path_q.insert(path_q.size(), '{path_vertex: 0, path_cost: 0, found: 0, last: 1});
            return;
        end
        len = 0;
        v = dst_reg;
        while (len < n) begin
            stack[len] = v;
            len++;
            if (!has_pred[v]) break;
            v = pred[v];
        end
        for (int i = 0; i < len; i++) begin
            o.path_vertex = VTX_BITS'(stack[len-1-i]);
            o.path_cost   = COST_BITS'(best_dist[dst_reg]);
            o.found       = 1'b1;
            o.last        = (i + 1 == len);
            path_q.insert(path_q.size(), o);
        end
    endfunction

    function automatic void predict_word(t_in_word w);
        case (w.cmd)
            CMD_ADD: begin
                store_edge(w.edge_from, w.edge_to, w.edge_weight);
                if (undir_reg) store_edge(w.edge_to, w.edge_from, w.edge_weight);
            end
            CMD_CLEAR: foreach (edge_w[k]) edge_w[k] = '0;
            CMD_RUN: predict_path();
            default: ;
        endcase
    endfunction

    task automatic send_word(t_in_word w, bit typed = 0, t_out_word tw = '0);
        while (!calm && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (typed) begin
            path_q.insert(path_q.size(), tw);
        end else begin
            predict_word(w);
        end
        items++;
    endtask

    // drain pending words, then let any edge write finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (path_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VERTEX_COUNT: n_reg     = d[4:0];
            CFG_UNDIRECTED:   undir_reg = d[0];
            CFG_START:        src_reg   = d[3:0];
            CFG_END:          dst_reg   = d[3:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_word mk(logic [1:0] c, int a, int b, int w);
        mk = '{cmd: c, edge_from: a[3:0], edge_to: b[3:0], edge_weight: w[15:0]};
    endfunction

    function automatic void add_item(t_in_word w, bit typed = 0, t_out_word tw = '0);
        rows.insert(rows.size(), '{kind: ROW_ITEM, idx: 0, data: 0, word: w, typed: typed,
                                  typed_word: tw});
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_BITS-1:0] idx, int d);
        rows.insert(rows.size(), '{kind: ROW_CFG, idx: idx, data: d[7:0], word: '0,
                                  typed: 0, typed_word: '0});
    endfunction

    // result checker and random sink stalls
    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (path_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %p", o_out);
                end else begin
                    e = path_q.pop_front();
                    if (o_out.path_vertex !== e.path_vertex || o_out.path_cost !== e.path_cost
                        || o_out.found !== e.found || o_out.last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch: expected %p got %p", e, o_out);
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    initial begin
        #(12.0 * 1500000);
        $display("shortest_path_finder_test NOT OK");
        $finish;
    end

    initial begin
        int r, n, k, sel;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        mismatches = 0;
        items = 0;
        calm = 0;
        foreach (edge_w[i]) edge_w[i] = '0;
        n_reg = 5'd16; undir_reg = 0; src_reg = 0; dst_reg = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_item(mk(CMD_RUN, 0, 0, 0), 1, '{path_vertex: 0, path_cost: 0, found: 1, last: 1});
        add_item(mk(CMD_UNUSED, 15, 15, 65535));
        add_item(mk(CMD_ADD, 0, 1, 65535));
        add_item(mk(CMD_ADD, 0, 1, 5));
        add_item(mk(CMD_ADD, 1, 2, 0));
        add_item(mk(CMD_ADD, 2, 15, 65535));
        add_item(mk(CMD_ADD, 0, 2, 5));
        add_item(mk(CMD_ADD, 14, 15, 1));
        add_cfg(CFG_END, 15);
        add_item(mk(CMD_RUN, 0, 0, 0));
        add_cfg(CFG_UNDIRECTED, 1);
        add_item(mk(CMD_ADD, 15, 3, 7));
        add_cfg(CFG_START, 3);
        add_cfg(CFG_END, 0);
        add_item(mk(CMD_RUN, 0, 0, 0));
        add_item(mk(CMD_CLEAR, 0, 0, 0));
        add_item(mk(CMD_RUN, 0, 0, 0), 1, '{path_vertex: 0, path_cost: 0, found: 0, last: 1});
        add_cfg(CFG_VERTEX_COUNT, 4);
        add_cfg(CFG_START, 9);
        add_item(mk(CMD_RUN, 0, 0, 0), 1, '{path_vertex: 0, path_cost: 0, found: 0, last: 1});
        add_cfg(CFG_VERTEX_COUNT, 0);
        add_cfg(CFG_START, 0);
        add_item(mk(CMD_RUN, 0, 0, 0), 1, '{path_vertex: 0, path_cost: 0, found: 1, last: 1});
        add_cfg(CFG_VERTEX_COUNT, 8'hff);
        add_cfg(CFG_UNDIRECTED, 0);
        add_cfg(CFG_END, 15);
        add_item(mk(CMD_ADD, 0, 15, 9));
        add_item(mk(CMD_ADD, 0, 5, 3));
        add_item(mk(CMD_ADD, 5, 15, 6));
        add_item(mk(CMD_RUN, 0, 0, 0));
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_word(rows[i].word, rows[i].typed, rows[i].typed_word);
            end
        end

        // random graphs, mostly well formed load-then-run phases
        while (items < 420) begin
            calm = (items > 200 && items < 280);
            wait_idle();
            r = $urandom_range(99);
            if (r < 10) n = 16;
            else if (r < 13) n = 0;
            else if (r < 16) n = $urandom_range(31, 17);
            else n = $urandom_range(8, 2);
            write_reg(CFG_VERTEX_COUNT, CFG_DATA_BITS'(n));
            if (n == 0) n = 1;
            if (n > 16) n = 16;
            write_reg(CFG_UNDIRECTED, CFG_DATA_BITS'($urandom_range(1)));
            sel = $urandom_range(99);
            write_reg(CFG_START, CFG_DATA_BITS'(sel < 10 ? $urandom_range(15)
                                                         : $urandom_range(n - 1)));
            write_reg(CFG_END, CFG_DATA_BITS'(sel > 90 ? $urandom_range(15)
                                                       : $urandom_range(n - 1)));
            if ($urandom_range(3) != 0) send_word(mk(CMD_CLEAR, $urandom, $urandom, $urandom));
            k = $urandom_range(3 * n);
            for (int j = 0; j < k; j++) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    send_word(mk(CMD_UNUSED, $urandom, $urandom, $urandom));
                end else if (r < 10) begin
                    send_word(mk(CMD_ADD, $urandom_range(15), $urandom_range(15), $urandom));
                end else begin
                    send_word(mk(CMD_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                                 r < 40 ? $urandom_range(65535) : $urandom_range(20)));
                end
            end
            send_word(mk(CMD_RUN, $urandom, $urandom, $urandom));
            if ($urandom_range(3) == 0) send_word(mk(CMD_RUN, $urandom, $urandom, $urandom));
        end

        calm = 0;
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && path_q.size() == 0) begin
            $display("shortest_path_finder_test OK");
        end else begin
            $display("shortest_path_finder_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
